// ===== src/sdia_pkg.sv =====
package sdia_pkg;

  localparam int VALUE_W         = 32;
  localparam int CHAR_W          = 6;
  localparam int OUT_TDATA_W     = 8;
  localparam int RADIX           = 10;
  localparam int NUM_POS         = 10;
  localparam int POS_W           = 4;
  localparam int DIGIT_W         = 4;
  // wide enough for nine times the top power of ten plus a sign bit
  localparam int WIDE_W          = 35;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;
  localparam logic [POS_W-1:0]  MAX_POS    = POS_W'(NUM_POS - 1);

  // multiples d * 10^k for every digit position k and digit d
  typedef logic [NUM_POS-1:0][RADIX-1:0][WIDE_W-1:0] mult_tbl_t;

  function automatic mult_tbl_t build_mult_tbl();
    mult_tbl_t         t;
    longint unsigned   p;
    p = 64'd1;
    for (int k = 0; k < NUM_POS; k++) begin
      for (int d = 0; d < RADIX; d++) begin
        t[k][d] = WIDE_W'(p * 64'(d));
      end
      p = p * 64'(RADIX);
    end
    return t;
  endfunction

  localparam mult_tbl_t MULT_TBL = build_mult_tbl();

  typedef struct packed {
    logic                 neg;
    logic [VALUE_W-1:0]   mag;
    logic [POS_W-1:0]     top_pos;
  } item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SIGN,
    BK_DIGIT
  } back_state_t;

endpackage

// ===== src/signed_int_to_decimal_ascii.sv =====
// Converts each 32-bit two's-complement input into its decimal text, one ASCII character
// per output transfer, most significant first, with a leading minus sign for negative values
// and tlast on the final character; zero gives "0" and the most negative value gives
// "-2147483648". The front end works out sign, magnitude and leading-digit position in the
// cycle of the input transfer and parks them in a queue of QUEUE_DEPTH entries, so inputs
// are taken while the previous number is still being printed. The back end first pulls a
// number from the queue, emitting nothing, and then emits the characters in order, each digit coming from
// a single compare-and-subtract step against a table of multiples of the position's power of
// ten; a number has 1 to 11 characters, and output back-pressure holds the back end. Reset
// clears the queue, the back-end state and the output valid flag; the character, remainder
// and position registers are not reset.
module signed_int_to_decimal_ascii #(
  parameter int QUEUE_DEPTH = sdia_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sdia_pkg::VALUE_W-1:0]     s_axis_tdata,   // [31:0] value
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [sdia_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [5:0] char_code, [7:6] zero
  output logic                             m_axis_tlast
);

  logic                        push;
  logic                        push_ready;
  sdia_pkg::item_t             push_item;
  logic                        q_valid;
  logic                        q_pop;
  sdia_pkg::item_t             q_item;
  logic [sdia_pkg::CHAR_W-1:0] out_char;

  sdia_front u_front (
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_value   (s_axis_tdata),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  sdia_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (q_valid),
    .rd_en    (q_pop),
    .rd_item  (q_item)
  );

  sdia_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (out_char),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = sdia_pkg::OUT_TDATA_W'(out_char);

endmodule

// ===== src/sdia_front.sv =====
module sdia_front (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sdia_pkg::VALUE_W-1:0] in_value,
  output logic                        push,
  input  logic                        push_ready,
  output sdia_pkg::item_t             push_item
);

  logic                         neg;
  logic [sdia_pkg::VALUE_W-1:0] mag;
  logic [sdia_pkg::POS_W-1:0]   top_pos;

  assign neg = in_value[sdia_pkg::VALUE_W-1];
  // the most negative value wraps to its own unsigned magnitude
  assign mag = neg ? (sdia_pkg::VALUE_W'(0) - in_value) : in_value;

  // position of the leading digit: largest k with mag >= 10^k
  always_comb begin
    top_pos = '0;
    for (int k = 1; k < sdia_pkg::NUM_POS; k++) begin
      if (sdia_pkg::WIDE_W'(mag) >= sdia_pkg::MULT_TBL[k][1]) begin
        top_pos = sdia_pkg::POS_W'(k);
      end
    end
  end

  assign in_ready          = push_ready;
  assign push              = in_valid && push_ready;
  assign push_item.neg     = neg;
  assign push_item.mag     = mag;
  assign push_item.top_pos = top_pos;

endmodule

// ===== src/sdia_queue.sv =====
module sdia_queue #(
  parameter int DEPTH = sdia_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  output logic            wr_ready,
  input  sdia_pkg::item_t wr_item,
  output logic            rd_valid,
  input  logic            rd_en,
  output sdia_pkg::item_t rd_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sdia_pkg::item_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_en && wr_ready;
  assign do_rd    = rd_en && rd_valid;
  assign rd_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== src/sdia_back.sv =====
module sdia_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  sdia_pkg::item_t             q_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sdia_pkg::CHAR_W-1:0] out_char,
  output logic                        out_last
);

  sdia_pkg::back_state_t state;
  sdia_pkg::back_state_t state_next;

  logic [sdia_pkg::VALUE_W-1:0] rem;
  logic [sdia_pkg::POS_W-1:0]   pos;

  logic                         step;
  logic                         emit;
  logic                         digit_step;
  logic [sdia_pkg::CHAR_W-1:0]  emit_char;
  logic                         emit_last;

  logic [sdia_pkg::RADIX-1:0][sdia_pkg::WIDE_W-1:0] diff;
  logic [sdia_pkg::DIGIT_W-1:0] digit;
  logic [sdia_pkg::WIDE_W-1:0]  rem_sel;

  // output register is free or its transfer completes this cycle
  assign step = !out_valid || out_ready;

  // digit at the current position: largest d with rem >= d * 10^pos
  always_comb begin
    diff    = '0;
    digit   = '0;
    rem_sel = sdia_pkg::WIDE_W'(rem);
    for (int j = 1; j < sdia_pkg::RADIX; j++) begin
      diff[j] = sdia_pkg::WIDE_W'(rem) - sdia_pkg::MULT_TBL[pos][j];
      if (!diff[j][sdia_pkg::WIDE_W-1]) begin
        digit   = sdia_pkg::DIGIT_W'(j);
        rem_sel = diff[j];
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sdia_pkg::BK_IDLE: begin
        if (step && q_valid) begin
          state_next = q_item.neg ? sdia_pkg::BK_SIGN : sdia_pkg::BK_DIGIT;
        end
      end
      sdia_pkg::BK_SIGN: begin
        if (step) begin
          state_next = sdia_pkg::BK_DIGIT;
        end
      end
      sdia_pkg::BK_DIGIT: begin
        if (step && pos == '0) begin
          state_next = sdia_pkg::BK_IDLE;
        end
      end
      default: state_next = sdia_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    emit       = 1'b0;
    digit_step = 1'b0;
    emit_char  = sdia_pkg::CHAR_ZERO;
    emit_last  = 1'b0;
    case (state)
      sdia_pkg::BK_IDLE: begin
        q_pop = step && q_valid;
      end
      sdia_pkg::BK_SIGN: begin
        emit      = step;
        emit_char = sdia_pkg::CHAR_MINUS;
      end
      sdia_pkg::BK_DIGIT: begin
        emit       = step;
        digit_step = step;
        emit_char  = sdia_pkg::CHAR_ZERO + sdia_pkg::CHAR_W'(digit);
        emit_last  = (pos == '0);
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sdia_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rem <= q_item.mag;
      pos <= q_item.top_pos;
    end else if (digit_step) begin
      rem <= rem_sel[sdia_pkg::VALUE_W-1:0];
      pos <= pos - sdia_pkg::POS_W'(1);
    end
    if (emit) begin
      out_char <= emit_char;
      out_last <= emit_last;
    end
  end

  // remainder always fits below the next power of ten, so a digit never exceeds nine
  assert property (@(posedge clk) disable iff (rst)
    (state == sdia_pkg::BK_DIGIT && pos != sdia_pkg::MAX_POS) |->
      (sdia_pkg::WIDE_W'(rem) < sdia_pkg::MULT_TBL[pos + sdia_pkg::POS_W'(1)][1]))
    else $error("remainder out of range for digit position");

  assert property (@(posedge clk) disable iff (rst)
    (state == sdia_pkg::BK_DIGIT) |-> (pos <= sdia_pkg::MAX_POS))
    else $error("digit position beyond the top position");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_char == sdia_pkg::CHAR_MINUS ||
                   (out_char >= sdia_pkg::CHAR_ZERO && out_char <= sdia_pkg::CHAR_NINE)))
    else $error("output character is neither a digit nor a minus sign");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_char == sdia_pkg::CHAR_MINUS) |-> !out_last)
    else $error("minus sign marked as final character");

  assert property (@(posedge clk) disable iff (rst)
    (state == sdia_pkg::BK_SIGN && step) |=> (state == sdia_pkg::BK_DIGIT && out_valid))
    else $error("sign not followed by digits");

endmodule
